// ===== src/svg_pkg.sv =====
package svg_pkg;

  // Fixed Q16.16 field width
  localparam int DATA_W = 32;
  // CORDIC datapath width, Q2.30 with headroom
  localparam int CW = 34;
  localparam int CFG_AW = 3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_AMPLITUDE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PERIOD    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CENTRE    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GRAD_EN   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GRAD_MASK = 3'd4;

  // 2*pi in Q3.29
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sh26DD3B6A;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sh40000000;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sh80000000;
  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFFFFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h80000000;

  // Sample data riding along the phase divider
  typedef struct packed {
    logic        dneg;
    logic [31:0] ud;
  } ph_tag_t;

  // Sample data riding along the CORDIC
  typedef struct packed {
    logic    flip;
    ph_tag_t ph;
  } cd_tag_t;

  // Finished value results plus gradient signs
  typedef struct packed {
    logic [DATA_W-1:0] mv;
    logic              mv_ovf;
    logic [DATA_W-1:0] ga;
    logic              neg_c;
    logic              neg_p;
  } res_t;

  // Data riding along the gradient dividers
  typedef struct packed {
    res_t res;
    logic ovf_c;
    logic ovf_p;
  } gr_tag_t;

  // Rotation angle per CORDIC step, in units of 2^-32 turn
  function automatic logic [31:0] turn_angle(input int idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      24: a = 32'h00000028;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000002;
      29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== src/sinusoid_value_and_gradient_core.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------
// input     | start, busy        | in_abscissa
// result    | out_valid (strobe) | out_model_value, out_grad_amplitude,
//           |                    | out_grad_period, out_grad_centre, out_overflow
// config    | cfg_we             | cfg_addr, cfg_wdata
//
// One transaction is accepted every cycle while busy is low; each result strobes once
// it has passed the 64-step phase divider, the CORDIC chain,
// the 32-step gradient dividers and nine register stages around them.
// Reset is synchronous, active low; busy is high during reset and in the cycle that
// follows it, and low afterwards. The receiver cannot stall, so nothing ever backs up.
module sinusoid_value_and_gradient_core
  import svg_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_abscissa,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_model_value,
  output logic signed [DATA_W-1:0] out_grad_amplitude,
  output logic signed [DATA_W-1:0] out_grad_period,
  output logic signed [DATA_W-1:0] out_grad_centre,
  output logic                     out_overflow
);

  localparam int PH_CELLS = 64;
  localparam int GR_CELLS = 32;
  localparam int LATENCY  = PH_CELLS + CORDIC_STAGES + GR_CELLS + 9;

  // Saturate a magnitude with sign; returns {overflow, value}
  function automatic logic [32:0] clamp_out(input logic [33:0] mag, input logic too_big,
                                            input logic neg);
    logic [33:0] limit;
    logic [33:0] m;
    logic        ovf;
    limit = neg ? 34'd2147483648 : 34'd2147483647;
    ovf   = too_big || (mag > limit);
    m     = ovf ? limit : mag;
    m     = neg ? (34'd0 - m) : m;
    return {ovf, m[31:0]};
  endfunction

  // Configuration registers
  logic signed [DATA_W-1:0] amplitude_r, centre_r;
  logic [30:0]              period_r;
  logic                     grad_en_r;
  logic [2:0]               grad_mask_r;
  logic [30:0]              p_eff_r;
  logic [61:0]              pp_r;
  logic [31:0]              ua_r;
  logic                     aneg_r;
  logic                     busy_r;
  logic                     accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= 32'sd65536;
      period_r    <= 31'd65536;
      centre_r    <= 32'sd0;
      grad_en_r   <= 1'b0;
      grad_mask_r <= 3'd7;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AMPLITUDE: amplitude_r <= cfg_wdata;
        REG_PERIOD:    period_r    <= cfg_wdata[30:0];
        REG_CENTRE:    centre_r    <= cfg_wdata;
        REG_GRAD_EN:   grad_en_r   <= cfg_wdata[0];
        REG_GRAD_MASK: grad_mask_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Derive divisor, its square and the amplitude magnitude
  always_ff @(posedge clk) begin
    p_eff_r <= (period_r == 31'd0) ? 31'd1 : period_r;
    pp_r    <= 62'(p_eff_r) * 62'(p_eff_r);
    ua_r    <= amplitude_r[31] ? (32'd0 - amplitude_r) : amplitude_r;
    aneg_r  <= amplitude_r[31];
  end

  // Hold off transactions in the cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Offset from the centre
  logic [32:0] d;
  logic        s0_vld_r;
  ph_tag_t     s0_tag_r, s0_tag_nxt;

  always_comb begin
    d               = {in_abscissa[31], in_abscissa} - {centre_r[31], centre_r};
    s0_tag_nxt.dneg = d[32];
    s0_tag_nxt.ud   = d[32] ? 32'(33'd0 - d) : d[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_tag_r <= s0_tag_nxt;
  end

  // Phase divider chain: low 32 quotient bits of (|d| * 2^32) / P
  logic        ph_vld [0:PH_CELLS];
  logic [30:0] ph_rem [0:PH_CELLS];
  logic [63:0] ph_dvd [0:PH_CELLS];
  logic [31:0] ph_quo [0:PH_CELLS];
  ph_tag_t     ph_tag [0:PH_CELLS];

  assign ph_vld[0] = s0_vld_r;
  assign ph_rem[0] = '0;
  assign ph_dvd[0] = {s0_tag_r.ud, 32'd0};
  assign ph_quo[0] = '0;
  assign ph_tag[0] = s0_tag_r;

  for (genvar k = 0; k < PH_CELLS; k++) begin : g_ph
    svg_phase_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (ph_vld[k]),
      .in_rem  (ph_rem[k]),
      .in_dvd  (ph_dvd[k]),
      .in_quo  (ph_quo[k]),
      .in_tag  (ph_tag[k]),
      .divisor (p_eff_r),
      .out_vld (ph_vld[k+1]),
      .out_rem (ph_rem[k+1]),
      .out_dvd (ph_dvd[k+1]),
      .out_quo (ph_quo[k+1]),
      .out_tag (ph_tag[k+1])
    );
  end

  // Fold phase into a quarter turn either side of zero
  logic [31:0]          phase;
  logic signed [CW-1:0] zs, fd_z_nxt, fd_z_r;
  logic                 fd_flip, fd_vld_r;
  cd_tag_t              fd_tag_r;

  always_comb begin
    phase    = ph_tag[PH_CELLS].dneg ? (32'd0 - ph_quo[PH_CELLS]) : ph_quo[PH_CELLS];
    zs       = $signed({{(CW-32){phase[31]}}, phase});
    fd_flip  = (zs > QUARTER_TURN) || (zs < -QUARTER_TURN);
    fd_z_nxt = zs;
    if (fd_flip) begin
      fd_z_nxt = (zs > 0) ? (zs - HALF_TURN) : (zs + HALF_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_vld_r <= 1'b0;
    end else begin
      fd_vld_r <= ph_vld[PH_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    fd_z_r        <= fd_z_nxt;
    fd_tag_r.flip <= fd_flip;
    fd_tag_r.ph   <= ph_tag[PH_CELLS];
  end

  // CORDIC chain
  logic                 cd_vld [0:CORDIC_STAGES];
  logic signed [CW-1:0] cd_x   [0:CORDIC_STAGES];
  logic signed [CW-1:0] cd_y   [0:CORDIC_STAGES];
  logic signed [CW-1:0] cd_z   [0:CORDIC_STAGES];
  cd_tag_t              cd_tag [0:CORDIC_STAGES];

  assign cd_vld[0] = fd_vld_r;
  assign cd_x[0]   = CORDIC_GAIN;
  assign cd_y[0]   = '0;
  assign cd_z[0]   = fd_z_r;
  assign cd_tag[0] = fd_tag_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cd
    svg_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (cd_vld[k]),
      .in_x    (cd_x[k]),
      .in_y    (cd_y[k]),
      .in_z    (cd_z[k]),
      .in_tag  (cd_tag[k]),
      .out_vld (cd_vld[k+1]),
      .out_x   (cd_x[k+1]),
      .out_y   (cd_y[k+1]),
      .out_z   (cd_z[k+1]),
      .out_tag (cd_tag[k+1])
    );
  end

  // Stage 1: undo the fold, take magnitudes, multiply by the amplitude
  logic signed [CW-1:0] c_val, s_val;
  logic [31:0]          cm, sm;
  logic                 p1_vld_r, p1_cneg_r, p1_sneg_r;
  logic [63:0]          p1_mv_r, p1_base_r;
  logic [31:0]          p1_cm_r;
  ph_tag_t              p1_tag_r;

  always_comb begin
    c_val = cd_tag[CORDIC_STAGES].flip ? -cd_x[CORDIC_STAGES] : cd_x[CORDIC_STAGES];
    s_val = cd_tag[CORDIC_STAGES].flip ? -cd_y[CORDIC_STAGES] : cd_y[CORDIC_STAGES];
    cm    = c_val[CW-1] ? 32'(-c_val) : c_val[31:0];
    sm    = s_val[CW-1] ? 32'(-s_val) : s_val[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= cd_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    p1_mv_r   <= 64'(ua_r) * 64'(cm);
    p1_base_r <= 64'(ua_r) * 64'(sm);
    p1_cm_r   <= cm;
    p1_cneg_r <= c_val[CW-1];
    p1_sneg_r <= s_val[CW-1];
    p1_tag_r  <= cd_tag[CORDIC_STAGES].ph;
  end

  // Stage 2: finish value and amplitude gradient, start times 2*pi
  logic [32:0] mv_sat;
  logic [31:0] ga_mag;
  logic        neg_mv, neg_as, base_nz;
  logic        p2_vld_r;
  res_t        p2_res_r, p2_res_nxt;
  logic [63:0] p2_pw0_r, p2_pw1_r;
  logic [31:0] p2_ud_r;

  always_comb begin
    neg_mv  = (aneg_r != p1_cneg_r) && (ua_r != 32'd0) && (p1_cm_r != 32'd0);
    mv_sat  = clamp_out(p1_mv_r[63:30], 1'b0, neg_mv);
    ga_mag  = {14'd0, p1_cm_r[31:14]};
    neg_as  = aneg_r != p1_sneg_r;
    base_nz = p1_base_r != 64'd0;
    p2_res_nxt.mv     = mv_sat[31:0];
    p2_res_nxt.mv_ovf = mv_sat[32];
    p2_res_nxt.ga     = p1_cneg_r ? (32'd0 - ga_mag) : ga_mag;
    p2_res_nxt.neg_c  = neg_as && base_nz;
    p2_res_nxt.neg_p  = (neg_as != p1_tag_r.dneg) && base_nz && (p1_tag_r.ud != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_res_r <= p2_res_nxt;
    p2_pw0_r <= 64'(p1_base_r[31:0]) * 64'(TWO_PI_Q29);
    p2_pw1_r <= 64'(p1_base_r[63:32]) * 64'(TWO_PI_Q29);
    p2_ud_r  <= p1_tag_r.ud;
  end

  // Stage 3: sum partial products into W
  logic        p3_vld_r;
  res_t        p3_res_r;
  logic [95:0] p3_w_r;
  logic [31:0] p3_ud_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p3_w_r   <= {32'd0, p2_pw0_r} + {p2_pw1_r, 32'd0};
    p3_res_r <= p2_res_r;
    p3_ud_r  <= p2_ud_r;
  end

  // Stage 4: W times |d|, three partial products
  logic        p4_vld_r;
  res_t        p4_res_r;
  logic [95:0] p4_w_r;
  logic [63:0] p4_q0_r, p4_q1_r, p4_q2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else begin
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p4_q0_r  <= 64'(p3_w_r[31:0]) * 64'(p3_ud_r);
    p4_q1_r  <= 64'(p3_w_r[63:32]) * 64'(p3_ud_r);
    p4_q2_r  <= 64'(p3_w_r[95:64]) * 64'(p3_ud_r);
    p4_w_r   <= p3_w_r;
    p4_res_r <= p3_res_r;
  end

  // Stage 5: sum partial products into Wp
  logic         p5_vld_r;
  res_t         p5_res_r;
  logic [95:0]  p5_w_r;
  logic [127:0] p5_wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else begin
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p5_wp_r  <= {64'd0, p4_q0_r} + {32'd0, p4_q1_r, 32'd0} + {p4_q2_r, 64'd0};
    p5_w_r   <= p4_w_r;
    p5_res_r <= p4_res_r;
  end

  // Stage 6: drop 43 fraction bits, flag quotients of 2^32 or more
  logic [20:0] top_c;
  logic [52:0] top_p;
  logic        ovf_c, ovf_p;
  logic        p6_vld_r;
  gr_tag_t     p6_tag_r;
  logic [30:0] p6_rc_r;
  logic [31:0] p6_dc_r, p6_dp_r;
  logic [61:0] p6_rp_r;

  always_comb begin
    top_c = p5_w_r[95:75];
    top_p = p5_wp_r[127:75];
    ovf_c = {10'd0, top_c} >= p_eff_r;
    ovf_p = {9'd0, top_p} >= pp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
    end else begin
      p6_vld_r <= p5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p6_tag_r.res   <= p5_res_r;
    p6_tag_r.ovf_c <= ovf_c;
    p6_tag_r.ovf_p <= ovf_p;
    p6_rc_r        <= ovf_c ? 31'd0 : 31'(top_c);
    p6_dc_r        <= p5_w_r[74:43];
    p6_rp_r        <= ovf_p ? 62'd0 : 62'(top_p);
    p6_dp_r        <= p5_wp_r[74:43];
  end

  // Gradient divider chain: centre by P, period by P squared
  logic        gr_vld [0:GR_CELLS];
  logic [30:0] gr_rc  [0:GR_CELLS];
  logic [31:0] gr_dc  [0:GR_CELLS];
  logic [31:0] gr_qc  [0:GR_CELLS];
  logic [61:0] gr_rp  [0:GR_CELLS];
  logic [31:0] gr_dp  [0:GR_CELLS];
  logic [31:0] gr_qp  [0:GR_CELLS];
  gr_tag_t     gr_tag [0:GR_CELLS];

  assign gr_vld[0] = p6_vld_r;
  assign gr_rc[0]  = p6_rc_r;
  assign gr_dc[0]  = p6_dc_r;
  assign gr_qc[0]  = '0;
  assign gr_rp[0]  = p6_rp_r;
  assign gr_dp[0]  = p6_dp_r;
  assign gr_qp[0]  = '0;
  assign gr_tag[0] = p6_tag_r;

  for (genvar k = 0; k < GR_CELLS; k++) begin : g_gr
    svg_grad_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (gr_vld[k]),
      .in_rc   (gr_rc[k]),
      .in_dc   (gr_dc[k]),
      .in_qc   (gr_qc[k]),
      .in_rp   (gr_rp[k]),
      .in_dp   (gr_dp[k]),
      .in_qp   (gr_qp[k]),
      .in_tag  (gr_tag[k]),
      .p_div   (p_eff_r),
      .pp_div  (pp_r),
      .out_vld (gr_vld[k+1]),
      .out_rc  (gr_rc[k+1]),
      .out_dc  (gr_dc[k+1]),
      .out_qc  (gr_qc[k+1]),
      .out_rp  (gr_rp[k+1]),
      .out_dp  (gr_dp[k+1]),
      .out_qp  (gr_qp[k+1]),
      .out_tag (gr_tag[k+1])
    );
  end

  // Output stage: saturate, mask, register
  logic [32:0] gc_sat, gp_sat;
  logic        en_a, en_p, en_c;
  logic        out_valid_r, out_ovf_r;
  logic [31:0] out_mv_r, out_ga_r, out_gp_r, out_gc_r;
  res_t        fin;

  always_comb begin
    fin    = gr_tag[GR_CELLS].res;
    gc_sat = clamp_out({2'b00, gr_qc[GR_CELLS]}, gr_tag[GR_CELLS].ovf_c, fin.neg_c);
    gp_sat = clamp_out({2'b00, gr_qp[GR_CELLS]}, gr_tag[GR_CELLS].ovf_p, fin.neg_p);
    en_a   = grad_en_r && grad_mask_r[0];
    en_p   = grad_en_r && grad_mask_r[1];
    en_c   = grad_en_r && grad_mask_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= gr_vld[GR_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    out_mv_r  <= fin.mv;
    out_ga_r  <= en_a ? fin.ga : 32'd0;
    out_gp_r  <= en_p ? gp_sat[31:0] : 32'd0;
    out_gc_r  <= en_c ? gc_sat[31:0] : 32'd0;
    out_ovf_r <= fin.mv_ovf || (en_p && gp_sat[32]) || (en_c && gc_sat[32]);
  end

  assign out_valid          = out_valid_r;
  assign out_model_value    = out_mv_r;
  assign out_grad_amplitude = out_ga_r;
  assign out_grad_period    = out_gp_r;
  assign out_grad_centre    = out_gc_r;
  assign out_overflow       = out_ovf_r;

  // Assertions
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> !busy)
    else $error("busy high after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("result strobe missing at pipeline latency");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    fd_vld_r |-> ((fd_z_r <= QUARTER_TURN) && (fd_z_r >= -QUARTER_TURN)))
    else $error("folded phase outside a quarter turn");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_model_value == SAT_POS || out_model_value == SAT_NEG ||
       out_grad_period == SAT_POS || out_grad_period == SAT_NEG ||
       out_grad_centre == SAT_POS || out_grad_centre == SAT_NEG))
    else $error("overflow flagged without a saturated field");

endmodule

// ===== src/svg_phase_cell.sv =====
module svg_phase_cell
  import svg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [30:0] in_rem,
  input  logic [63:0] in_dvd,
  input  logic [31:0] in_quo,
  input  ph_tag_t     in_tag,
  input  logic [30:0] divisor,
  output logic        out_vld,
  output logic [30:0] out_rem,
  output logic [63:0] out_dvd,
  output logic [31:0] out_quo,
  output ph_tag_t     out_tag
);

  logic        vld_r;
  logic [30:0] rem_r, rem_nxt;
  logic [63:0] dvd_r;
  logic [31:0] quo_r;
  ph_tag_t     tag_r;
  logic [31:0] trial, diff;
  logic        ge;

  // Restoring step: bring in one dividend bit, subtract if it fits
  always_comb begin
    trial   = {in_rem, in_dvd[63]};
    diff    = trial - {1'b0, divisor};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? diff[30:0] : trial[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= {in_dvd[62:0], 1'b0};
    quo_r <= {in_quo[30:0], ge};
    tag_r <= in_tag;
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_dvd = dvd_r;
  assign out_quo = quo_r;
  assign out_tag = tag_r;

endmodule

// ===== src/svg_cordic_cell.sv =====
module svg_cordic_cell
  import svg_pkg::*;
#(
  parameter int STAGE = 0
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_z,
  input  cd_tag_t              in_tag,
  output logic                 out_vld,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [CW-1:0] out_z,
  output cd_tag_t              out_tag
);

  localparam logic signed [CW-1:0] ANG = $signed(CW'(turn_angle(STAGE)));

  logic                 vld_r;
  logic signed [CW-1:0] x_r, y_r, z_r;
  logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [CW-1:0] dx, dy;
  cd_tag_t              tag_r;

  // Rotate toward zero residual angle
  always_comb begin
    dx = in_y >>> STAGE;
    dy = in_x >>> STAGE;
    if (!in_z[CW-1]) begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ANG;
    end else begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    tag_r <= in_tag;
  end

  assign out_vld = vld_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;
  assign out_tag = tag_r;

endmodule

// ===== src/svg_grad_cell.sv =====
module svg_grad_cell
  import svg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [30:0] in_rc,
  input  logic [31:0] in_dc,
  input  logic [31:0] in_qc,
  input  logic [61:0] in_rp,
  input  logic [31:0] in_dp,
  input  logic [31:0] in_qp,
  input  gr_tag_t     in_tag,
  input  logic [30:0] p_div,
  input  logic [61:0] pp_div,
  output logic        out_vld,
  output logic [30:0] out_rc,
  output logic [31:0] out_dc,
  output logic [31:0] out_qc,
  output logic [61:0] out_rp,
  output logic [31:0] out_dp,
  output logic [31:0] out_qp,
  output gr_tag_t     out_tag
);

  logic        vld_r;
  logic [30:0] rc_r, rc_nxt;
  logic [31:0] dc_r, qc_r, dp_r, qp_r;
  logic [61:0] rp_r, rp_nxt;
  gr_tag_t     tag_r;
  logic [31:0] tc, dfc;
  logic [62:0] tp, dfp;
  logic        gec, gep;

  // Centre divider step, divisor P
  always_comb begin
    tc     = {in_rc, in_dc[31]};
    dfc    = tc - {1'b0, p_div};
    gec    = tc >= {1'b0, p_div};
    rc_nxt = gec ? dfc[30:0] : tc[30:0];
  end

  // Period divider step, divisor P squared
  always_comb begin
    tp     = {in_rp, in_dp[31]};
    dfp    = tp - {1'b0, pp_div};
    gep    = tp >= {1'b0, pp_div};
    rp_nxt = gep ? dfp[61:0] : tp[61:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rc_r  <= rc_nxt;
    dc_r  <= {in_dc[30:0], 1'b0};
    qc_r  <= {in_qc[30:0], gec};
    rp_r  <= rp_nxt;
    dp_r  <= {in_dp[30:0], 1'b0};
    qp_r  <= {in_qp[30:0], gep};
    tag_r <= in_tag;
  end

  assign out_vld = vld_r;
  assign out_rc  = rc_r;
  assign out_dc  = dc_r;
  assign out_qc  = qc_r;
  assign out_rp  = rp_r;
  assign out_dp  = dp_r;
  assign out_qp  = qp_r;
  assign out_tag = tag_r;

endmodule

// ===== tb/sv/sinusoid_value_and_gradient_core_test.sv =====
`timescale 1ns / 100ps

module sinusoid_value_and_gradient_core_test
  import svg_pkg::*;
;

  localparam int STAGES = 24;
  localparam int PIPE_DELAY = 105 + STAGES;
  localparam logic [63:0] TAU_Q29 = 64'd3373259426;
  localparam longint GAIN_Q30 = 64'sh26DD3B6A;
  localparam longint QTR = 64'sh40000000;
  localparam longint HALF = 64'sh80000000;

  // Rotation angle per stage, 2^-32 turn
  localparam logic [31:0] ROT_ANGLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000};

  typedef struct {
    logic [31:0] value;
    logic [31:0] d_amp;
    logic [31:0] d_period;
    logic [31:0] d_centre;
    logic        ovf;
  } sinusoid_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [DATA_W-1:0] in_abscissa = '0;
  logic out_valid;
  logic signed [DATA_W-1:0] out_model_value, out_grad_amplitude;
  logic signed [DATA_W-1:0] out_grad_period, out_grad_centre;
  logic out_overflow;

  // Register shadow copy
  logic signed [31:0] amp_reg = 32'sd65536;
  logic [30:0] period_reg = 31'd65536;
  logic signed [31:0] centre_reg = '0;
  logic grad_en_reg = 1'b0;
  logic [2:0] grad_mask_reg = 3'd7;

  logic signed [31:0] abscissa_q[$];
  sinusoid_t sinusoid_q[$];
  int idle_pct = 0;
  int errors = 0;

  sinusoid_value_and_gradient_core #(.CORDIC_STAGES(STAGES)) DUT (.*);

  always #5 clk = ~clk;

  // Clamp a sign and magnitude to the 32 bit signed range
  function automatic logic [31:0] saturate(logic [63:0] mag, bit too_big, bit neg,
                                           inout bit ovf);
    logic [63:0] lim;
    lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
    if (too_big || mag > lim) begin
      ovf = 1'b1;
      mag = lim;
    end
    return neg ? 32'(-mag) : mag[31:0];
  endfunction

  function automatic sinusoid_t eval_sinusoid(logic signed [31:0] x);
    longint a, d, z, xx, yy, dx, dy, c, s;
    logic [63:0] ud, p, frac, ua, uc, us, base;
    logic [31:0] phase;
    logic [127:0] w, q;
    bit flip, ovf, neg_as;
    sinusoid_t r;
    a = longint'(amp_reg);
    p = (period_reg == 0) ? 64'd1 : {33'd0, period_reg};
    d = longint'(x) - longint'(centre_reg);
    ud = d < 0 ? -d : d;
    frac = ((ud % p) << 32) / p;
    phase = frac[31:0];
    if (d < 0) phase = -phase;
    // Fold the phase into a quarter turn, then rotate
    z = longint'({32'd0, phase});
    if (z >= HALF) z -= 2 * HALF;
    flip = 0;
    if (z > QTR || z < -QTR) begin
      z = z > 0 ? z - HALF : z + HALF;
      flip = 1;
    end
    xx = GAIN_Q30;
    yy = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = yy >>> i;
      dy = xx >>> i;
      if (z >= 0) begin
        xx -= dx; yy += dy; z -= longint'({32'd0, ROT_ANGLE[i]});
      end else begin
        xx += dx; yy -= dy; z += longint'({32'd0, ROT_ANGLE[i]});
      end
    end
    c = flip ? -xx : xx;
    s = flip ? -yy : yy;
    ua = a < 0 ? -a : a;
    uc = c < 0 ? -c : c;
    us = s < 0 ? -s : s;
    ovf = 0;
    r.value = saturate((ua * uc) >> 30, 1'b0, (a < 0) != (c < 0) && ua != 0 && c != 0, ovf);
    r.d_amp = '0;
    r.d_period = '0;
    r.d_centre = '0;
    if (grad_en_reg && grad_mask_reg[0])
      r.d_amp = saturate(uc >> 14, 1'b0, c < 0, ovf);
    if (grad_en_reg && grad_mask_reg[2:1] != 0) begin
      base = ua * us;
      neg_as = (a < 0) != (s < 0);
      w = 128'(base) * 128'(TAU_Q29);
      if (grad_mask_reg[2]) begin
        q = (w / 128'(p)) >> 43;
        r.d_centre = saturate(q[63:0], q[127:64] != 0, neg_as && base != 0, ovf);
      end
      if (grad_mask_reg[1]) begin
        q = ((w * 128'(ud)) / 128'(p) / 128'(p)) >> 43;
        r.d_period = saturate(q[63:0], q[127:64] != 0,
                              (neg_as != (d < 0)) && base != 0 && ud != 0, ovf);
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_AMPLITUDE: amp_reg = data;
      REG_PERIOD:    period_reg = data[30:0];
      REG_CENTRE:    centre_reg = data;
      REG_GRAD_EN:   grad_en_reg = data[0];
      REG_GRAD_MASK: grad_mask_reg = data[2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [31:0] amp, logic [31:0] per, logic [31:0] ctr,
                           logic en, logic [2:0] mask);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_PERIOD, per);
    write_reg(REG_CENTRE, ctr);
    write_reg(REG_GRAD_EN, {31'd0, en});
    write_reg(REG_GRAD_MASK, {29'd0, mask});
  endtask

  // Abscissa extremes and points around the centre
  task automatic add_directed();
    logic signed [31:0] ctr, q;
    ctr = centre_reg;
    q = {1'b0, period_reg} >> 2;
    abscissa_q.push_back(32'sd0);
    abscissa_q.push_back(32'sd1);
    abscissa_q.push_back(-32'sd1);
    abscissa_q.push_back(32'h7FFFFFFF);
    abscissa_q.push_back(32'h80000000);
    abscissa_q.push_back(ctr);
    abscissa_q.push_back(ctr + q);
    abscissa_q.push_back(ctr - q);
    abscissa_q.push_back(ctr + 2 * q);
    abscissa_q.push_back(ctr + {1'b0, period_reg});
    abscissa_q.push_back(ctr - {1'b0, period_reg});
    abscissa_q.push_back(32'h55555555);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        abscissa_q.push_back(centre_reg + $signed($urandom_range(65536 * 8)) - 32'sd262144);
      else
        abscissa_q.push_back($urandom);
    end
  endtask

  // Wait until every transaction has gone in and come back out
  task automatic drain();
    do @(negedge clk);
    while (abscissa_q.size() != 0 || start || sinusoid_q.size() != 0);
    repeat (PIPE_DELAY + 10) @(negedge clk);
  endtask

  // Drive samples; predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) sinusoid_q.push_back(eval_sinusoid(in_abscissa));
      if (!start || !busy) begin
        if (abscissa_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_abscissa <= abscissa_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h, actual %h", name, want, got);
    end
  endtask

  // Check each result strobe against the oldest prediction
  always @(posedge clk) begin
    sinusoid_t e;
    if (rst_n && out_valid) begin
      if (sinusoid_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_model_value);
      end else begin
        e = sinusoid_q.pop_front();
        report("model_value", e.value, out_model_value);
        report("grad_amplitude", e.d_amp, out_grad_amplitude);
        report("grad_period", e.d_period, out_grad_period);
        report("grad_centre", e.d_centre, out_grad_centre);
        report("overflow", {31'd0, e.ovf}, {31'd0, out_overflow});
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // Reset settings, gradients off
    @(negedge clk);
    add_directed();
    drain();
    idle_pct = 0;
    configure(32'd65536, 32'd262144, 32'd0, 1'b1, 3'd7);
    add_directed();
    add_random(200);
    drain();
    idle_pct = 53;
    configure(32'h7FFFFFFF, 32'd1, 32'h80000000, 1'b1, 3'd7);
    add_directed();
    add_random(240);
    drain();
    idle_pct = 28;
    configure(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 3'd5);
    add_directed();
    add_random(240);
    drain();
    idle_pct = 0;
    // Zero period acts as the smallest one
    configure(32'd0, 32'd0, $urandom, 1'b1, 3'd2);
    add_random(200);
    drain();
    idle_pct = 53;
    configure($urandom, $urandom_range(1, 1 << 20), $urandom, 1'b0,
              3'($urandom_range(7)));
    add_random(200);
    drain();
    for (int k = 0; k < 4; k++) begin
      idle_pct = (k == 0) ? 28 : (k == 1) ? 0 : (k == 2) ? 53 : 28;
      configure($urandom, (k == 3) ? {1'b1, 31'($urandom)} : $urandom_range(1, 1 << 24),
                $urandom, 1'b1, 3'($urandom_range(7)));
      add_random(220);
      drain();
    end
    if (errors == 0)
      $display("sinusoid_value_and_gradient_core_test: done, clean");
    else
      $display("sinusoid_value_and_gradient_core_test: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("sinusoid_value_and_gradient_core_test: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/svg_pkg.sv
src/svg_phase_cell.sv
src/svg_cordic_cell.sv
src/svg_grad_cell.sv
src/sinusoid_value_and_gradient_core.sv
tb/sv/sinusoid_value_and_gradient_core_test.sv
